// ===== hw/rtl/wrs_pkg.sv =====
package wrs_pkg;

    // Fixed field and store widths.
    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 32;
    localparam int M2_W     = 48;
    localparam int ENTRY_W  = MEAN_W + M2_W;
    localparam int STD_W    = 15;
    localparam int ROOT_W   = M2_W / 2;
    localparam int FRAMES_W = 24;
    localparam int NUM_COMP = 4;

    // Top-level sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MEAN,
        ST_DIFF,
        ST_MUL,
        ST_M2,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DONE
    } t_state;

    // Step commands from the sequencer to every lane.
    typedef struct packed {
        logic load;
        logic div_go_mean;
        logic div_go_var;
        logic mean_upd;
        logic diff;
        logic mul;
        logic m2_upd;
        logic sqrt_go;
        logic wr_en;
        logic wr_zero;
    } t_lane_ctl;

    // Status that a lane returns to the sequencer.
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } t_lane_sts;

    // Rounds a Q1.31 mean to Q1.15, ties up, saturating at the top.
    function automatic logic signed [SAMPLE_W-1:0] mean_to_q15(
        input logic signed [MEAN_W-1:0] m
    );
        logic signed [MEAN_W:0]   t;
        logic signed [SAMPLE_W:0] hi;
        t  = {m[MEAN_W-1], m} + (MEAN_W+1)'(33'sd32768);
        hi = t[MEAN_W:MEAN_W-SAMPLE_W];
        if (hi > (SAMPLE_W+1)'(17'sd32767)) begin
            return SAMPLE_W'(16'sh7fff);
        end
        return hi[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/wrs_ram.sv =====
module wrs_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== hw/rtl/wrs_div.sv =====
module wrs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    localparam int CW = $clog2(NUM_W);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One restoring step: shift in the next dividend bit and try the divisor.
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        ge    = trial >= {1'b0, i_den};
        diff  = trial - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(NUM_W-1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/wrs_sqrt.sv =====
module wrs_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wrs_pkg::M2_W-1:0]   i_val,
    output logic [wrs_pkg::ROOT_W-1:0] o_root,
    output logic                       o_done
);

    import wrs_pkg::*;

    localparam int CW = $clog2(ROOT_W);
    localparam int RW = ROOT_W + 2;

    logic [M2_W-1:0]   r_val;
    logic [RW-1:0]     r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [RW-1:0]     shifted;
    logic [RW-1:0]     trial;
    logic              ge;

    // One digit per cycle: bring down two bits and try root*4+1.
    always_comb begin
        shifted = {r_rem[RW-3:0], r_val[M2_W-1:M2_W-2]};
        trial   = {r_root, 2'b01};
        ge      = shifted >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(ROOT_W-1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[M2_W-3:0], 2'b00};
            r_rem  <= ge ? shifted - trial : shifted;
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ===== hw/rtl/wrs_lane.sv =====
module wrs_lane #(
    parameter int COUNT_BITS = 24,
    parameter int AW         = 4,
    parameter int DEPTH      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wrs_pkg::t_lane_ctl                  i_ctl,
    output wrs_pkg::t_lane_sts                  o_sts,
    input  logic [AW-1:0]                       i_rd_addr,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [wrs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [COUNT_BITS-1:0]               i_count,
    output logic signed [wrs_pkg::SAMPLE_W-1:0] o_mean_q15,
    output logic [wrs_pkg::STD_W-1:0]           o_std
);

    import wrs_pkg::*;

    logic [ENTRY_W-1:0]       rd_data;
    logic [ENTRY_W-1:0]       wr_data;
    logic signed [MEAN_W-1:0] s31;
    logic signed [MEAN_W-1:0] rd_mean;
    logic signed [MEAN_W-1:0] r_mean;
    logic [M2_W-1:0]          r_m2;
    logic signed [MEAN_W:0]   r_d1;
    logic signed [MEAN_W:0]   r_d2;
    logic [2*MEAN_W-1:0]      r_prod;
    logic [MEAN_W:0]          neg1;
    logic [MEAN_W:0]          neg2;
    logic [MEAN_W-1:0]        mag1;
    logic [MEAN_W-1:0]        mag2;
    logic [M2_W-1:0]          div_num;
    logic [M2_W-1:0]          div_quo;
    logic                     div_done;
    logic [ROOT_W-1:0]        root;
    logic                     sqrt_done;
    logic signed [MEAN_W:0]   step;
    logic signed [MEAN_W+1:0] mean_sum;
    logic signed [MEAN_W-1:0] mean_new;
    logic [MEAN_W-1:0]        p;
    logic [M2_W:0]            m2_add;
    logic [M2_W-1:0]          m2_new;

    // This lane's slice of the mean and residual-sum store.
    wrs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    assign wr_data = i_ctl.wr_zero ? '0 : {r_mean, r_m2};
    assign rd_mean = rd_data[ENTRY_W-1:M2_W];
    assign s31     = {i_sample, 16'h0000};

    // Magnitudes of the two residuals; both fit in 32 bits.
    always_comb begin
        neg1 = -r_d1;
        neg2 = -r_d2;
        mag1 = r_d1[MEAN_W] ? neg1[MEAN_W-1:0] : r_d1[MEAN_W-1:0];
        mag2 = r_d2[MEAN_W] ? neg2[MEAN_W-1:0] : r_d2[MEAN_W-1:0];
    end

    // The shared divider serves d1/n and then M2/n.
    assign div_num = i_ctl.div_go_mean ? {{(M2_W-MEAN_W){1'b0}}, mag1} : r_m2;

    wrs_div #(
        .NUM_W (M2_W),
        .DEN_W (COUNT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_go_mean | i_ctl.div_go_var),
        .i_num   (div_num),
        .i_den   (i_count),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    wrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.sqrt_go),
        .i_val   (div_quo),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;

    // Mean step with the quotient signed like d1, clamped to 32 bits.
    always_comb begin
        step = r_d1[MEAN_W] ? -$signed({1'b0, div_quo[MEAN_W-1:0]})
                            :  $signed({1'b0, div_quo[MEAN_W-1:0]});
        mean_sum = {{2{r_mean[MEAN_W-1]}}, r_mean} + {step[MEAN_W], step};
        if (mean_sum > (MEAN_W+2)'(34'sh07fffffff)) begin
            mean_new = {1'b0, {(MEAN_W-1){1'b1}}};
        end else if (mean_sum < -(MEAN_W+2)'(34'sh080000000)) begin
            mean_new = {1'b1, {(MEAN_W-1){1'b0}}};
        end else begin
            mean_new = mean_sum[MEAN_W-1:0];
        end
    end

    // Residual-sum update: floored at zero, saturating at the top.
    always_comb begin
        p      = r_prod[2*MEAN_W-1:MEAN_W];
        m2_add = {1'b0, r_m2} + {{(M2_W+1-MEAN_W){1'b0}}, p};
        if (r_d1[MEAN_W] != r_d2[MEAN_W]) begin
            m2_new = (r_m2 > {{(M2_W-MEAN_W){1'b0}}, p})
                   ? r_m2 - {{(M2_W-MEAN_W){1'b0}}, p} : '0;
        end else begin
            m2_new = m2_add[M2_W] ? '1 : m2_add[M2_W-1:0];
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mean <= rd_mean;
            r_m2   <= rd_data[M2_W-1:0];
            r_d1   <= {s31[MEAN_W-1], s31} - {rd_mean[MEAN_W-1], rd_mean};
        end
        if (i_ctl.mean_upd) begin
            r_mean <= mean_new;
        end
        if (i_ctl.diff) begin
            r_d2 <= {s31[MEAN_W-1], s31} - {r_mean[MEAN_W-1], r_mean};
        end
        if (i_ctl.mul) begin
            r_prod <= mag1 * mag2;
        end
        if (i_ctl.m2_upd) begin
            r_m2 <= m2_new;
        end
    end

    assign o_mean_q15 = mean_to_q15(r_mean);
    assign o_std      = (root > ROOT_W'(32767)) ? '1 : root[STD_W-1:0];

endmodule

// ===== hw/rtl/welford_running_std_deviation_top.sv =====
// Update item: from acceptance to result, two 48-step divisions, a 24-step square root and the
// sequencing states between them. Item with no frame yet or an element out of range skips them.
// Clear item: sweeps all ELEMENT_SLOTS entries of the store to zero.
// One item at a time; the result register lets the next item enter before it is taken.
// Reset is synchronous, active low; it zeroes the frame counter and then sweeps all
// ELEMENT_SLOTS entries of the store, during which no item is accepted.
module welford_running_std_deviation_top #(
    parameter int ELEMENT_SLOTS = 16,
    parameter int COUNT_BITS    = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [3:0]                          i_element,
    input  logic signed [wrs_pkg::SAMPLE_W-1:0] i_sample_x,
    input  logic signed [wrs_pkg::SAMPLE_W-1:0] i_sample_y,
    input  logic signed [wrs_pkg::SAMPLE_W-1:0] i_sample_z,
    input  logic signed [wrs_pkg::SAMPLE_W-1:0] i_sample_len,
    input  logic                                i_frame_start,
    input  logic                                i_clear,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [3:0]                          o_out_element,
    output logic signed [wrs_pkg::SAMPLE_W-1:0] o_mean_x,
    output logic signed [wrs_pkg::SAMPLE_W-1:0] o_mean_y,
    output logic signed [wrs_pkg::SAMPLE_W-1:0] o_mean_z,
    output logic signed [wrs_pkg::SAMPLE_W-1:0] o_mean_len,
    output logic [wrs_pkg::STD_W-1:0]           o_std_x,
    output logic [wrs_pkg::STD_W-1:0]           o_std_y,
    output logic [wrs_pkg::STD_W-1:0]           o_std_z,
    output logic [wrs_pkg::STD_W-1:0]           o_std_len,
    output logic [wrs_pkg::FRAMES_W-1:0]        o_frames_seen,
    output logic                                o_no_frame_error
);

    import wrs_pkg::*;

    localparam int AW = (ELEMENT_SLOTS > 1) ? $clog2(ELEMENT_SLOTS) : 1;

    t_state                     r_state;
    t_state                     n_state;
    t_lane_ctl                  ctl;
    t_lane_sts                  sts [NUM_COMP];
    logic [3:0]                 r_elem;
    logic signed [SAMPLE_W-1:0] r_smp [NUM_COMP];
    logic [COUNT_BITS-1:0]      r_count;
    logic [COUNT_BITS-1:0]      n_count;
    logic                       r_clr_item;
    logic                       r_update;
    logic                       r_inrange;
    logic                       r_err;
    logic [AW-1:0]              r_sweep;
    logic                       sweep_last;
    logic [AW-1:0]              item_addr;
    logic [AW-1:0]              wr_addr;
    logic [31:0]                elem_ext;
    logic [31:0]                count_ext;
    logic                       in_accept;
    logic                       in_range;
    logic                       out_free;
    logic                       out_load;
    logic signed [SAMPLE_W-1:0] lane_mean [NUM_COMP];
    logic [STD_W-1:0]           lane_std [NUM_COMP];
    logic                       r_ovalid;
    logic [3:0]                 r_oelem;
    logic signed [SAMPLE_W-1:0] r_omean [NUM_COMP];
    logic [STD_W-1:0]           r_ostd [NUM_COMP];
    logic [FRAMES_W-1:0]        r_oframes;
    logic                       r_oerr;

    // Input handshake and per-item decode.
    assign in_accept  = i_valid && (r_state == ST_IDLE);
    assign o_stall    = (r_state != ST_IDLE);
    assign elem_ext   = {28'h0, i_element};
    assign in_range   = elem_ext < 32'(ELEMENT_SLOTS);
    assign item_addr  = AW'({28'h0, r_elem});
    assign sweep_last = (r_sweep == AW'(ELEMENT_SLOTS - 1));
    assign wr_addr    = (r_state == ST_CLEAR) ? r_sweep : item_addr;
    assign out_free   = !r_ovalid || !i_stall;
    assign out_load   = (r_state == ST_DONE) && out_free;

    // Saturating frame counter value that this item uses as the divisor.
    always_comb begin
        n_count = r_count;
        if (i_frame_start && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (sweep_last) begin
                    n_state = r_clr_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_clear ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ:      n_state = ST_LOAD;
            ST_LOAD:      n_state = r_update ? ST_DIV1_GO : ST_DONE;
            ST_DIV1_GO:   n_state = ST_DIV1_WAIT;
            ST_DIV1_WAIT: n_state = sts[0].div_done ? ST_MEAN : ST_DIV1_WAIT;
            ST_MEAN:      n_state = ST_DIFF;
            ST_DIFF:      n_state = ST_MUL;
            ST_MUL:       n_state = ST_M2;
            ST_M2:        n_state = ST_DIV2_GO;
            ST_DIV2_GO:   n_state = ST_DIV2_WAIT;
            ST_DIV2_WAIT: n_state = sts[0].div_done ? ST_SQRT_GO : ST_DIV2_WAIT;
            ST_SQRT_GO:   n_state = ST_SQRT_WAIT;
            ST_SQRT_WAIT: n_state = sts[0].sqrt_done ? ST_DONE : ST_SQRT_WAIT;
            ST_DONE:      n_state = out_free ? ST_IDLE : ST_DONE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Lane commands decoded from the state.
    always_comb begin
        ctl             = '0;
        ctl.load        = (r_state == ST_LOAD);
        ctl.div_go_mean = (r_state == ST_DIV1_GO);
        ctl.mean_upd    = (r_state == ST_MEAN);
        ctl.diff        = (r_state == ST_DIFF);
        ctl.mul         = (r_state == ST_MUL);
        ctl.m2_upd      = (r_state == ST_M2);
        ctl.div_go_var  = (r_state == ST_DIV2_GO);
        ctl.sqrt_go     = (r_state == ST_SQRT_GO);
        ctl.wr_en       = (r_state == ST_CLEAR) || (r_state == ST_DIV2_GO);
        ctl.wr_zero     = (r_state == ST_CLEAR);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_count    <= '0;
            r_clr_item <= 1'b0;
            r_sweep    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (in_accept) begin
                r_clr_item <= i_clear;
                r_count    <= i_clear ? '0 : n_count;
            end
        end
    end

    // Item registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_elem    <= i_element;
            r_smp[0]  <= i_sample_x;
            r_smp[1]  <= i_sample_y;
            r_smp[2]  <= i_sample_z;
            r_smp[3]  <= i_sample_len;
            r_inrange <= in_range && !i_clear;
            r_err     <= !i_clear && (n_count == '0);
            r_update  <= !i_clear && (n_count != '0) && in_range;
        end
    end

    // One lane per component, all stepped in lockstep.
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        wrs_lane #(
            .COUNT_BITS (COUNT_BITS),
            .AW         (AW),
            .DEPTH      (ELEMENT_SLOTS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .o_sts      (sts[c]),
            .i_rd_addr  (item_addr),
            .i_wr_addr  (wr_addr),
            .i_sample   (r_smp[c]),
            .i_count    (r_count),
            .o_mean_q15 (lane_mean[c]),
            .o_std      (lane_std[c])
        );
    end

    // Merge stage: gather the lanes into the result register.
    assign count_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oelem   <= r_elem;
            r_oframes <= count_ext[FRAMES_W-1:0];
            r_oerr    <= r_err && !r_clr_item;
            for (int c = 0; c < NUM_COMP; c++) begin
                r_omean[c] <= r_inrange ? lane_mean[c] : '0;
                r_ostd[c]  <= r_update ? lane_std[c] : '0;
            end
        end
    end

    assign o_valid          = r_ovalid;
    assign o_out_element    = r_oelem;
    assign o_mean_x         = r_omean[0];
    assign o_mean_y         = r_omean[1];
    assign o_mean_z         = r_omean[2];
    assign o_mean_len       = r_omean[3];
    assign o_std_x          = r_ostd[0];
    assign o_std_y          = r_ostd[1];
    assign o_std_z          = r_ostd[2];
    assign o_std_len        = r_ostd[3];
    assign o_frames_seen    = r_oframes;
    assign o_no_frame_error = r_oerr;

endmodule

// ===== dv/tb.sv =====
module tb;
    import wrs_pkg::*;

    localparam int ELEMENT_SLOTS = 16;
    localparam int COUNT_BITS    = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam logic [63:0] M2_TOP = (64'd1 << M2_W) - 64'd1;

    // One beat into the block: an element's four samples and its flags.
    typedef struct {
        logic [3:0]                 element;
        logic signed [SAMPLE_W-1:0] smp [NUM_COMP];
        logic                       frame_start;
        logic                       clear;
    } t_sample_beat;

    // One beat out of the block.
    typedef struct {
        logic [3:0]                 element;
        logic signed [SAMPLE_W-1:0] mean [NUM_COMP];
        logic [STD_W-1:0]           sd [NUM_COMP];
        logic [FRAMES_W-1:0]        frames;
        logic                       no_frame;
    } t_stats_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic [3:0] i_element;
    logic signed [SAMPLE_W-1:0] i_sample_x, i_sample_y, i_sample_z, i_sample_len;
    logic i_frame_start;
    logic i_clear;
    logic o_valid;
    logic i_stall;
    logic [3:0] o_out_element;
    logic signed [SAMPLE_W-1:0] o_mean_x, o_mean_y, o_mean_z, o_mean_len;
    logic [STD_W-1:0] o_std_x, o_std_y, o_std_z, o_std_len;
    logic [FRAMES_W-1:0] o_frames_seen;
    logic o_no_frame_error;

    // Shadow statistics store and frame counter.
    logic signed [MEAN_W-1:0] shadow_mean [ELEMENT_SLOTS*NUM_COMP];
    logic [63:0]              shadow_m2 [ELEMENT_SLOTS*NUM_COMP];
    logic [COUNT_BITS-1:0]    shadow_frames;

    t_stats_beat pending_stats [$];
    int fail_count;
    int beats_sent;
    int beats_checked;
    int clears_sent;
    int no_frame_seen;
    bit hold_req;
    bit calm;
    logic signed [SAMPLE_W-1:0] cluster_base [ELEMENT_SLOTS];

    welford_running_std_deviation_top #(
        .ELEMENT_SLOTS(ELEMENT_SLOTS),
        .COUNT_BITS   (COUNT_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element       (i_element),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .i_sample_z      (i_sample_z),
        .i_sample_len    (i_sample_len),
        .i_frame_start   (i_frame_start),
        .i_clear         (i_clear),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_element   (o_out_element),
        .o_mean_x        (o_mean_x),
        .o_mean_y        (o_mean_y),
        .o_mean_z        (o_mean_z),
        .o_mean_len      (o_mean_len),
        .o_std_x         (o_std_x),
        .o_std_y         (o_std_y),
        .o_std_z         (o_std_z),
        .o_std_len       (o_std_len),
        .o_frames_seen   (o_frames_seen),
        .o_no_frame_error(o_no_frame_error)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Q1.31 mean rounded to Q1.15, ties up, clipped at the top.
    function automatic logic signed [SAMPLE_W-1:0] round_mean(logic signed [MEAN_W-1:0] m);
        longint q;
        q = ((longint'(m) + 64'sd2147483648 + 64'sd32768) >>> 16) - 64'sd32768;
        if (q > 32767) q = 32767;
        return q[SAMPLE_W-1:0];
    endfunction

    // Integer square root, floored.
    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Welford update of one stored component with divisor n.
    function automatic void welford_update(int idx, logic signed [SAMPLE_W-1:0] s, longint n);
        longint s31, mu, d1, d2;
        logic [127:0] prod;
        logic [63:0] mag1, mag2, p, m2;
        s31 = longint'(s) * 65536;
        mu  = longint'(shadow_mean[idx]);
        m2  = shadow_m2[idx];
        d1  = s31 - mu;
        mu  = mu + d1 / n;
        if (mu > 64'sd2147483647) mu = 64'sd2147483647;
        if (mu < -64'sd2147483648) mu = -64'sd2147483648;
        shadow_mean[idx] = mu[MEAN_W-1:0];
        d2   = s31 - mu;
        mag1 = (d1 < 0) ? -d1 : d1;
        mag2 = (d2 < 0) ? -d2 : d2;
        prod = {64'd0, mag1} * {64'd0, mag2};
        p    = prod[95:32];
        if ((d1 < 0) != (d2 < 0)) begin
            m2 = (m2 > p) ? m2 - p : 64'd0;
        end else begin
            m2 = m2 + p;
            if (m2 > M2_TOP) m2 = M2_TOP;
        end
        shadow_m2[idx] = m2;
    endfunction

    function automatic void clear_shadow();
        foreach (shadow_mean[k]) begin
            shadow_mean[k] = '0;
            shadow_m2[k]   = '0;
        end
        shadow_frames = '0;
    endfunction

    // Works out the statistics beat that one accepted sample beat produces.
    function automatic t_stats_beat predict_stats(t_sample_beat b);
        t_stats_beat r;
        logic [63:0] root;
        bit in_range;
        r.element  = b.element;
        r.frames   = '0;
        r.no_frame = 1'b0;
        for (int c = 0; c < NUM_COMP; c++) begin
            r.mean[c] = '0;
            r.sd[c]   = '0;
        end
        if (b.clear) begin
            clear_shadow();
            return r;
        end
        in_range = int'(b.element) < ELEMENT_SLOTS;
        if (b.frame_start && shadow_frames != COUNT_TOP) shadow_frames++;
        if (shadow_frames == 0) begin
            r.no_frame = 1'b1;
        end else if (in_range) begin
            for (int c = 0; c < NUM_COMP; c++)
                welford_update(int'(b.element) * NUM_COMP + c, b.smp[c], longint'(shadow_frames));
        end
        if (in_range) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                r.mean[c] = round_mean(shadow_mean[int'(b.element) * NUM_COMP + c]);
                if (shadow_frames != 0) begin
                    root = floor_root(shadow_m2[int'(b.element) * NUM_COMP + c]
                                      / longint'(shadow_frames));
                    r.sd[c] = (root > 64'd32767) ? 15'h7fff : root[STD_W-1:0];
                end
            end
        end
        r.frames = FRAMES_W'(shadow_frames);
        return r;
    endfunction

    // Offers one beat, holds it until accepted, then idles at random.
    task automatic send_beat(t_sample_beat b);
        int gap;
        i_valid       <= 1'b1;
        i_element     <= b.element;
        i_sample_x    <= b.smp[0];
        i_sample_y    <= b.smp[1];
        i_sample_z    <= b.smp[2];
        i_sample_len  <= b.smp[3];
        i_frame_start <= b.frame_start;
        i_clear       <= b.clear;
        do @(posedge i_clk); while (o_stall);
        pending_stats.push_back(predict_stats(b));
        beats_sent++;
        if (b.clear) clears_sent++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_sample_beat make_beat(int el, int sx, int sy, int sz, int sl,
                                               bit fs, bit clr);
        t_sample_beat b;
        b.element     = el[3:0];
        b.smp[0]      = sx[SAMPLE_W-1:0];
        b.smp[1]      = sy[SAMPLE_W-1:0];
        b.smp[2]      = sz[SAMPLE_W-1:0];
        b.smp[3]      = sl[SAMPLE_W-1:0];
        b.frame_start = fs;
        b.clear       = clr;
        return b;
    endfunction

    // Sample for random beats: mostly near an element's center, some wide, some at the rails.
    function automatic int pick_sample(int el);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return int'(cluster_base[el]) + $urandom_range(0, 600) - 300;
        if (r < 85) return $urandom_range(0, 65535) - 32768;
        return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    endfunction

    // Compares one field and reports a mismatch.
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Checks each accepted result beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_stats_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: result beat with no prediction waiting, element %0d",
                         $time, o_out_element);
                fail_count++;
            end else begin
                e = pending_stats.pop_front();
                beats_checked++;
                if (e.no_frame) no_frame_seen++;
                check_field("out_element", e.element, o_out_element);
                check_field("mean_x", e.mean[0], o_mean_x);
                check_field("mean_y", e.mean[1], o_mean_y);
                check_field("mean_z", e.mean[2], o_mean_z);
                check_field("mean_len", e.mean[3], o_mean_len);
                check_field("std_x", e.sd[0], o_std_x);
                check_field("std_y", e.sd[1], o_std_y);
                check_field("std_z", e.sd[2], o_std_z);
                check_field("std_len", e.sd[3], o_std_len);
                check_field("frames_seen", e.frames, o_frames_seen);
                check_field("no_frame_error", e.no_frame, o_no_frame_error);
            end
        end
    end

    // Result side: random stalls, or one long hold-off on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Updates before any frame, then the rails of every sample field.
    task automatic test_directed();
        send_beat(make_beat(0, 1000, -1000, 5, 7, 1'b0, 1'b0));
        send_beat(make_beat(15, 32767, -32768, 0, -1, 1'b0, 1'b0));
        send_beat(make_beat(0, 32767, 32767, -32768, -32768, 1'b1, 1'b0));
        send_beat(make_beat(0, -32768, -32768, 32767, 32767, 1'b1, 1'b0));
        send_beat(make_beat(0, 32767, -32768, 32767, -32768, 1'b1, 1'b0));
        send_beat(make_beat(15, -32768, 32767, -1, 0, 1'b0, 1'b0));
        send_beat(make_beat(15, 32767, -32768, 0, -1, 1'b0, 1'b0));
        send_beat(make_beat(7, 0, 0, 0, 0, 1'b0, 1'b0));
        send_beat(make_beat(8, -1, 1, -2, 2, 1'b1, 1'b0));
        send_beat(make_beat(8, 21845, -21846, 10922, -10923, 1'b1, 1'b0));
        send_beat(make_beat(0, -32768, 32767, -32768, 32767, 1'b1, 1'b0));
    endtask

    // Clear wins over frame start and samples, then an update with no frame.
    task automatic test_clear();
        send_beat(make_beat(5, 32767, -32768, 12345, -1, 1'b1, 1'b1));
        send_beat(make_beat(0, 100, 200, 300, 400, 1'b0, 1'b0));
        send_beat(make_beat(5, -32768, 32767, -1, 1, 1'b0, 1'b1));
        send_beat(make_beat(3, 4000, -4000, 16384, -16384, 1'b1, 1'b0));
        send_beat(make_beat(3, 4100, -3900, 16000, -16000, 1'b0, 1'b0));
    endtask

    // Long hold-off on the result side while beats keep coming.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) begin
            send_beat(make_beat($urandom_range(0, 15), pick_sample(1), pick_sample(2),
                                pick_sample(3), pick_sample(4), k == 0, 1'b0));
        end
    endtask

    // Frames of random elements with random content, rare clears.
    task automatic test_random(int count);
        int el;
        bit fs;
        bit clr;
        for (int k = 0; k < count; k++) begin
            calm = (k % 300) >= 240;
            el   = $urandom_range(0, 15);
            clr  = $urandom_range(0, 199) == 0;
            fs   = $urandom_range(0, 5) == 0;
            send_beat(make_beat(el, pick_sample(el), pick_sample(el), pick_sample(el),
                                pick_sample(el), fs, clr));
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_element     = '0;
        i_sample_x    = '0;
        i_sample_y    = '0;
        i_sample_z    = '0;
        i_sample_len  = '0;
        i_frame_start = 1'b0;
        i_clear       = 1'b0;
        fail_count    = 0;
        beats_sent    = 0;
        beats_checked = 0;
        clears_sent   = 0;
        no_frame_seen = 0;
        hold_req      = 1'b0;
        calm          = 1'b0;
        clear_shadow();
        foreach (cluster_base[k]) begin
            cluster_base[k] = SAMPLE_W'(int'($urandom_range(0, 60000)) - 30000);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_clear();
        test_backpressure();
        test_random(1220);

        i_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d sample beats (%0d clears), checked %0d result beats.",
                 beats_sent, clears_sent, beats_checked);
        $display("Updates with no frame yet: %0d; final frame count %0d.",
                 no_frame_seen, shadow_frames);
        if (fail_count == 0) begin
            $display("welford_running_std_deviation_top verification clean");
        end else begin
            $display("welford_running_std_deviation_top verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #40000000;
        $display("welford_running_std_deviation_top verification failed");
        $finish;
    end

endmodule
